[src/cidw_pkg.sv]
// Shared types and constants for the card ID whitelist controller.
// Used by the scanner, the top level and the checkers; depends on nothing.
package cidw_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int ID_LOW_W  = 64;
    localparam int ID_HIGH_W = 16;
    localparam int ID_LEN_W  = 4;
    localparam int REST_W    = ID_LEN_W + ID_HIGH_W;
    localparam int KEY_W     = ID_LOW_W + REST_W;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 16;

    localparam int MODE_W  = 2;
    localparam int OUTC_W  = 2;
    localparam int LEVEL_W = 5;

    localparam logic [MODE_W-1:0] OPM_AUTH     = 2'd0;
    localparam logic [MODE_W-1:0] OPM_VERIFY   = 2'd1;
    localparam logic [MODE_W-1:0] OPM_REGISTER = 2'd2;

    localparam logic [OUTC_W-1:0] OUT_NONE    = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_SUCCESS = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_ERROR   = 2'd2;
    localparam logic [OUTC_W-1:0] OUT_SILENT  = 2'd3;

    // Status from the table scanner to the control FSM.
    typedef struct packed {
        logic done;
        logic found;
    } scan_stat_t;

endpackage

[src/cidw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependencies.
module cidw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/cidw_scan.sv]
// Table scanner: walks the stored IDs below the fill count, one RAM read per
// cycle, through a single key comparator. Uses cidw_pkg.
module cidw_scan #(
    parameter int TABLE_DEPTH = cidw_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]       fill,
    input  logic [cidw_pkg::KEY_W-1:0]             key,
    input  logic [cidw_pkg::KEY_W-1:0]             rd_data,
    output logic                                   rd_en,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
    output cidw_pkg::scan_stat_t                   stat
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic             busy_reg,  busy_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pend_reg,  pend_next;
    logic             found_reg, found_next;
    logic             done_reg,  done_next;
    logic             issue_go;

    assign issue_go = busy_reg && (issue_reg < fill);

    always_comb
    begin
        busy_next  = busy_reg;
        issue_next = issue_reg;
        pend_next  = 1'b0;
        found_next = found_reg;
        done_next  = 1'b0;
        if (start)
        begin
            busy_next  = 1'b1;
            issue_next = '0;
            found_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (issue_go)
            begin
                issue_next = issue_reg + 1'b1;
            end
            pend_next = issue_go;
            // compare the entry read last cycle
            if (pend_reg && (rd_data == key))
            begin
                found_next = 1'b1;
            end
            if (!issue_go && !pend_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    assign rd_en      = issue_go;
    assign rd_addr    = issue_reg[IDX_W-1:0];
    assign stat.done  = done_reg;
    assign stat.found = found_reg;

endmodule

[src/card_id_whitelist_controller.sv]
// Channel   | Dir | Fields (tdata low bit up)                                   | tuser
// s_axis    | in  | id_low[63:0] id_high[79:64] id_length[83:80] button[84]    | card_valid
// m_axis    | out | outcome[1:0] mode_now[3:2] fill_level[8:4]                 | -
//
// Each result waits on the table scan: one comparator checks one stored ID per cycle from the RAM
// read port. The next item can be accepted in the cycle after the result is loaded.
// s_axis_tready is high only while no item is being worked on; a finished
// result waits in the output register while the next item is accepted.
// A stalled m_axis holds its item. rst_n clears mode, fill count and handshakes;
// the ID table needs no clearing since only entries below the fill count are read.
// Depends on cidw_pkg, cidw_ram and cidw_scan.
module card_id_whitelist_controller #(
    parameter int TABLE_DEPTH = cidw_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // id_low[63:0], id_high[79:64], id_length[83:80], button_level[84], zero[87:85]
    input  logic [cidw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // card_valid[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // outcome[1:0], mode_now[3:2], fill_level[8:4], zero[15:9]
    output logic [cidw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg, state_next;

    // captured item
    logic [cidw_pkg::ID_LOW_W-1:0] lo_reg;
    logic [cidw_pkg::REST_W-1:0]   rest_reg;
    logic                          card_reg;
    logic                          button_reg;

    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [cidw_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic                          prev_btn_reg, prev_btn_next;

    // computed result waiting for the output register
    logic [cidw_pkg::OUTC_W-1:0]   res_outc_reg, res_outc_next;

    logic                          out_valid_reg, out_valid_next;
    logic [cidw_pkg::OUTC_W-1:0]   out_outc_reg;
    logic [cidw_pkg::MODE_W-1:0]   out_mode_reg;
    logic [cidw_pkg::LEVEL_W-1:0]  out_level_reg;

    logic                          accept;
    logic                          load_out;
    logic                          wr_en;
    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;
    logic [cidw_pkg::KEY_W-1:0]    rd_data;
    logic [cidw_pkg::KEY_W-1:0]    key;
    cidw_pkg::scan_stat_t          stat;
    logic                          card_hit;
    logic [cidw_pkg::MODE_W-1:0]   mode_mid;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign key      = {rest_reg, lo_reg};
    assign card_hit = card_reg && (rest_reg[cidw_pkg::REST_W-1:cidw_pkg::ID_HIGH_W] != '0);
    assign load_out = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    cidw_ram #(
        .WIDTH (cidw_pkg::KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .wr_data (key),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cidw_scan #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .fill    (fill_reg),
        .key     (key),
        .rd_data (rd_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .stat    (stat)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg     <= s_axis_tdata[63:0];
            rest_reg   <= s_axis_tdata[83:64];
            card_reg   <= s_axis_tuser;
            button_reg <= s_axis_tdata[84];
        end
        res_outc_reg <= res_outc_next;
        if (load_out)
        begin
            out_outc_reg  <= res_outc_reg;
            out_mode_reg  <= mode_reg;
            out_level_reg <= cidw_pkg::LEVEL_W'(fill_reg);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        mode_next     = mode_reg;
        prev_btn_next = prev_btn_reg;
        res_outc_next = res_outc_reg;
        wr_en         = 1'b0;
        mode_mid      = mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                res_outc_next = cidw_pkg::OUT_NONE;
                if (card_hit)
                begin
                    case (mode_reg)
                        cidw_pkg::OPM_REGISTER:
                        begin
                            if ((fill_reg >= CNT_W'(TABLE_DEPTH)) || stat.found)
                            begin
                                res_outc_next = cidw_pkg::OUT_ERROR;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                fill_next     = fill_reg + 1'b1;
                                res_outc_next = cidw_pkg::OUT_SUCCESS;
                            end
                        end
                        cidw_pkg::OPM_AUTH:
                        begin
                            res_outc_next = stat.found ? cidw_pkg::OUT_SUCCESS
                                                       : cidw_pkg::OUT_ERROR;
                        end
                        default:
                        begin
                            if (stat.found)
                            begin
                                mode_mid      = cidw_pkg::OPM_REGISTER;
                                res_outc_next = cidw_pkg::OUT_SILENT;
                            end
                            else
                            begin
                                res_outc_next = cidw_pkg::OUT_ERROR;
                            end
                        end
                    endcase
                end
                // release edge of the button flips the mode
                mode_next = mode_mid;
                if (!prev_btn_reg && button_reg)
                begin
                    mode_next = (mode_mid == cidw_pkg::OPM_AUTH) ? cidw_pkg::OPM_VERIFY
                                                                : cidw_pkg::OPM_AUTH;
                end
                prev_btn_next = button_reg;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            mode_reg      <= cidw_pkg::OPM_REGISTER;
            prev_btn_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            mode_reg      <= mode_next;
            prev_btn_reg  <= prev_btn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_level_reg, out_mode_reg, out_outc_reg};

endmodule

[src/cidw_checker.sv]
// Port-level checks for the card ID whitelist controller, bound to the top level.
// Depends on cidw_pkg and card_id_whitelist_controller.
module cidw_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cidw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result item changed");

    // an accepted item keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after an item");

    // a silent verify match leaves register or authenticate mode, never verify
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == cidw_pkg::OUT_SILENT))
        |-> (m_axis_tdata[3:2] != cidw_pkg::OPM_VERIFY))
        else $error("silent match reported in verify mode");

    // reported mode is always a defined mode
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[3:2] == cidw_pkg::OPM_AUTH)
                        || (m_axis_tdata[3:2] == cidw_pkg::OPM_VERIFY)
                        || (m_axis_tdata[3:2] == cidw_pkg::OPM_REGISTER)))
        else $error("undefined mode reported");

endmodule

bind card_id_whitelist_controller cidw_checker u_cidw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/whitelist_checker.sv]
// Checker for the card ID whitelist controller: watches both stream channels,
// predicts each result from its own copy of the ID table and mode, and compares.
// Depends on cidw_pkg.
`timescale 1ns / 100ps

module whitelist_checker
    import cidw_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [OUTC_W-1:0]  outcome;
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] fill;
    } pass_result_t;

    logic [ID_LOW_W-1:0] low_tab [DEPTH];
    logic [REST_W-1:0]   rest_tab[DEPTH];
    int unsigned         stored;
    logic [MODE_W-1:0]   cur_mode;
    logic                last_btn;
    pass_result_t        result_q[$];
    int                  mismatch_cnt = 0;

    assign errors = mismatch_cnt;

    function automatic pass_result_t predict_pass(input logic card,
                                                  input logic [ID_LOW_W-1:0] lo,
                                                  input logic [ID_HIGH_W-1:0] hi,
                                                  input logic [ID_LEN_W-1:0] len,
                                                  input logic btn);
        pass_result_t r;
        logic         hit;
        r.outcome = OUT_NONE;
        hit = 1'b0;
        if (card && len != '0)
        begin
            for (int k = 0; k < stored; k++)
                if (low_tab[k] == lo && rest_tab[k] == {len, hi})
                    hit = 1'b1;
            if (cur_mode == OPM_REGISTER)
            begin
                if (stored >= DEPTH || hit)
                    r.outcome = OUT_ERROR;
                else
                begin
                    low_tab[stored]  = lo;
                    rest_tab[stored] = {len, hi};
                    stored++;
                    r.outcome = OUT_SUCCESS;
                end
            end
            else if (cur_mode == OPM_AUTH)
                r.outcome = hit ? OUT_SUCCESS : OUT_ERROR;
            else if (hit)
            begin
                // verify hit drops into register mode without a signal
                cur_mode  = OPM_REGISTER;
                r.outcome = OUT_SILENT;
            end
            else
                r.outcome = OUT_ERROR;
        end
        // release edge of the button, after the card is handled
        if (!last_btn && btn)
            cur_mode = (cur_mode == OPM_AUTH) ? OPM_VERIFY : OPM_AUTH;
        last_btn = btn;
        r.mode = cur_mode;
        r.fill = LEVEL_W'(stored);
        return r;
    endfunction

    always @(posedge clk)
    begin
        pass_result_t want;
        pass_result_t got;
        if (!rst_n)
        begin
            stored   = 0;
            cur_mode = OPM_REGISTER;
            last_btn = 1'b1;
            result_q.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.outcome = m_tdata[OUTC_W-1:0];
                got.mode    = m_tdata[OUTC_W +: MODE_W];
                got.fill    = m_tdata[OUTC_W+MODE_W +: LEVEL_W];
                if (result_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected result outcome %0d mode %0d fill %0d",
                                 $realtime, got.outcome, got.mode, got.fill);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.outcome != want.outcome || got.mode != want.mode ||
                        got.fill != want.fill)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: outcome/mode/fill expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, want.outcome, want.mode, want.fill,
                                     got.outcome, got.mode, got.fill);
                    end
                end
            end
            if (s_tvalid && s_tready)
                result_q.push_back(predict_pass(s_tuser,
                                                s_tdata[ID_LOW_W-1:0],
                                                s_tdata[ID_LOW_W +: ID_HIGH_W],
                                                s_tdata[ID_LOW_W+ID_HIGH_W +: ID_LEN_W],
                                                s_tdata[KEY_W]));
            pending <= result_q.size();
        end
    end

endmodule

[tb/testbench.sv]
// Top of the whitelist controller testbench: clock, reset, directed and random
// polling passes with idle and stall phases; verdict from whitelist_checker.
// Depends on cidw_pkg, card_id_whitelist_controller and whitelist_checker.
`timescale 1ns / 100ps

module testbench;
    import cidw_pkg::*;

    localparam int POOL       = 24;
    localparam int PHASE_LEN  = 475;
    localparam int CYCLE_CAP  = 1000000;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_LEN   = 400;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int errors;
    int pending;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int cycles = 0;
    int out_taken = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit btn_level = 1'b1;

    logic [ID_LOW_W-1:0]  pool_lo [POOL];
    logic [ID_HIGH_W-1:0] pool_hi [POOL];
    logic [ID_LEN_W-1:0]  pool_len[POOL];

    always #6 clk = ~clk;

    card_id_whitelist_controller uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    whitelist_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    // Receiver: random stalls, plus one long hold-off to back up the block.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                out_taken <= out_taken + 1;
            if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && out_taken >= HOLD_AFTER)
            begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_LEN;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic offer_pass(input bit card, input logic [ID_LOW_W-1:0] lo,
                              input logic [ID_HIGH_W-1:0] hi,
                              input logic [ID_LEN_W-1:0] len, input bit btn);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, btn, len, hi, lo};
        s_axis_tuser  <= card;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Hold the sender until every expected result has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic build_pool();
        logic [ID_LEN_W-1:0] len;
        for (int i = 0; i < POOL; i++)
        begin
            if (i < 18)
            begin
                len = 4'($urandom_range(1, 10));
                pool_len[i] = len;
                pool_lo[i]  = {$urandom, $urandom};
                if (len < 8)
                    pool_lo[i] = pool_lo[i] & ~({ID_LOW_W{1'b1}} >> (8 * len));
                pool_hi[i] = (len == 10) ? 16'($urandom) :
                             (len == 9) ? {8'($urandom), 8'h00} : 16'h0000;
            end
            else
            begin
                // near misses of earlier IDs: only length or one high bit differs
                pool_lo[i]  = pool_lo[i-18];
                pool_hi[i]  = pool_hi[i-18];
                pool_len[i] = pool_len[i-18];
                if (i % 2 == 0)
                    pool_len[i] = (pool_len[i] < 15) ? pool_len[i] + 4'd1 : 4'd14;
                else
                    pool_hi[i][$urandom_range(0, ID_HIGH_W-1)] ^= 1'b1;
            end
        end
    endtask

    task automatic random_pass();
        int                   pick;
        int                   sel;
        bit                   card;
        logic [ID_LOW_W-1:0]  lo;
        logic [ID_HIGH_W-1:0] hi;
        logic [ID_LEN_W-1:0]  len;
        if ($urandom_range(0, 99) < 20)
            btn_level = ~btn_level;
        pick = $urandom_range(0, 99);
        card = 1'b1;
        lo   = {$urandom, $urandom};
        hi   = 16'($urandom);
        len  = 4'($urandom_range(0, 15));
        if (pick < 10)
            card = 1'b0;
        else if (pick < 15)
            len = '0;
        else if (pick < 80)
        begin
            sel = $urandom_range(0, POOL-1);
            lo  = pool_lo[sel];
            hi  = pool_hi[sel];
            len = pool_len[sel];
        end
        offer_pass(card, lo, hi, len, btn_level);
    endtask

    localparam logic [ID_LOW_W-1:0] LO_ONES = {ID_LOW_W{1'b1}};
    localparam logic [ID_LOW_W-1:0] LO_PAT  = 64'hA5A5_0F0F_3C3C_9696;

    initial
    begin
        build_pool();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register mode after reset, empty table
        offer_pass(1'b0, LO_ONES, 16'hFFFF, 4'd10, 1'b1);
        offer_pass(1'b1, '0, 16'h0000, 4'd1, 1'b1);
        offer_pass(1'b1, LO_ONES, 16'hFFFF, 4'd10, 1'b1);
        offer_pass(1'b1, LO_ONES, 16'hFFFF, 4'd10, 1'b1);   // duplicate
        offer_pass(1'b1, LO_PAT, 16'h1234, 4'd0, 1'b1);     // empty identifier
        offer_pass(1'b1, LO_PAT, 16'h5A5A, 4'd15, 1'b1);    // length above ten
        offer_pass(1'b0, LO_ONES, 16'hFFFF, 4'd15, 1'b1);
        offer_pass(1'b0, '0, 16'h0000, 4'd0, 1'b0);
        // card handled before the release edge takes register to authenticate
        offer_pass(1'b1, LO_ONES, 16'hFFFF, 4'd10, 1'b1);
        offer_pass(1'b1, '0, 16'h0000, 4'd1, 1'b1);
        offer_pass(1'b1, '0, 16'h0000, 4'd2, 1'b1);
        offer_pass(1'b1, LO_ONES, 16'hFFFE, 4'd10, 1'b1);
        offer_pass(1'b0, '0, 16'h0000, 4'd0, 1'b0);
        offer_pass(1'b0, '0, 16'h0000, 4'd0, 1'b1);         // to verify
        offer_pass(1'b1, LO_PAT, 16'h5A5A, 4'd14, 1'b1);
        offer_pass(1'b1, LO_PAT, 16'h5A5A, 4'd15, 1'b0);    // silent switch
        offer_pass(1'b0, '0, 16'h0000, 4'd0, 1'b1);         // register to authenticate
        offer_pass(1'b0, '0, 16'h0000, 4'd0, 1'b0);
        offer_pass(1'b0, '0, 16'h0000, 4'd0, 1'b1);
        offer_pass(1'b0, '0, 16'h0000, 4'd0, 1'b0);
        offer_pass(1'b1, LO_ONES, 16'h0000, 4'd8, 1'b1);    // verify miss, back to auth
        offer_pass(1'b1, LO_ONES, 16'hFFFF, 4'd10, 1'b0);
        offer_pass(1'b0, '0, 16'h0000, 4'd0, 1'b1);
        offer_pass(1'b1, '0, 16'h0000, 4'd1, 1'b1);         // verify hit, no edge

        for (int ph = 0; ph < 4; ph++)
        begin
            drain_results();
            @(negedge clk);
            tx_idle_pct = (ph == 1) ? 56 : (ph == 3) ? 34 : 0;
            rx_stall_pct <= (ph == 2) ? 56 : (ph == 3) ? 34 : 0;
            @(posedge clk);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                random_pass();
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
